// ----- design/crc_checked_frame_receiver_top_defines.svh -----
// ----------------------------------------------------------------------------
// crc checked frame receiver assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define CCFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form of the above
`define CCFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `CCFR_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// ----- design/ccfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfr package
// types, constants and crc function of the frame receiver
// ----------------------------------------------------------------------------
package ccfr_pkg;

   localparam int CRC_BYTES = 4;
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0] TERM_RESET = 8'd10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      POS_FIRST  = 3'd0,
      POS_SECOND = 3'd1,
      POS_PACKED = 3'd2,
      POS_CHK_HI = 3'd3,
      POS_CHK_LO = 3'd4,
      POS_TERM   = 3'd5
   } pos_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_TERM = 2'd1,
      STATUS_BAD_CRC = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [7:0] first_value;
      logic signed [7:0] second_value;
      logic [3:0] low_nibble;
      logic [3:0] high_nibble;
      logic [15:0] received_check;
      logic [15:0] computed_check;
      logic term_ok;
   } frame_rec_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- design/ccfr_if.sv -----
// ----------------------------------------------------------------------------
// ccfr channel interfaces
// valid/ready channels for received bytes and frame results
// ----------------------------------------------------------------------------
interface ccfr_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface ccfr_rsp_if;
   logic valid;
   logic ready;
   logic signed [7:0] first_value;
   logic signed [7:0] second_value;
   logic [3:0] low_nibble;
   logic [3:0] high_nibble;
   logic [15:0] received_check;
   logic [15:0] computed_check;
   logic [1:0] status;

   modport source (output valid, output first_value, output second_value,
                   output low_nibble, output high_nibble, output received_check,
                   output computed_check, output status, input ready);
   modport sink (input valid, input first_value, input second_value,
                 input low_nibble, input high_nibble, input received_check,
                 input computed_check, input status, output ready);
endinterface

// ----- design/ccfr_front.sv -----
// ----------------------------------------------------------------------------
// ccfr front
// frame assembly, running crc and terminator check per received byte
// ----------------------------------------------------------------------------
module ccfr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_data_byte,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic q_full,
   output logic q_push,
   output ccfr_pkg::frame_rec_type q_rec
);
   import ccfr_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] term_ff;
   logic [7:0] first_ff, second_ff, packed_ff;
   logic [15:0] check_ff;
   logic at_term, accept;

   assign at_term   = (pos_ff >= POS_TERM);
   assign req_ready = !(at_term && q_full);
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && at_term;

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (accept) begin
         case (pos_ff)
            POS_FIRST: begin
               pos_in = POS_SECOND;
               crc_in = crc_feed(CRC_INIT, req_data_byte);
            end
            POS_SECOND: begin
               pos_in = POS_PACKED;
               crc_in = crc_feed(crc_ff, req_data_byte);
            end
            POS_PACKED: begin
               pos_in = POS_CHK_HI;
               crc_in = crc_feed(crc_feed(crc_ff, {4'h0, req_data_byte[3:0]}),
                                 {4'h0, req_data_byte[7:4]});
            end
            POS_CHK_HI: begin
               pos_in = POS_CHK_LO;
            end
            POS_CHK_LO: begin
               pos_in = POS_TERM;
            end
            default: begin
               pos_in = POS_FIRST;
               crc_in = CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         crc_ff  <= CRC_INIT;
         term_ff <= TERM_RESET;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         if (csr_wr_en) begin
            term_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (pos_ff)
            POS_FIRST:  first_ff        <= req_data_byte;
            POS_SECOND: second_ff       <= req_data_byte;
            POS_PACKED: packed_ff       <= req_data_byte;
            POS_CHK_HI: check_ff[15:8]  <= req_data_byte;
            POS_CHK_LO: check_ff[7:0]   <= req_data_byte;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      q_rec.first_value    = first_ff;
      q_rec.second_value   = second_ff;
      q_rec.low_nibble     = packed_ff[3:0];
      q_rec.high_nibble    = packed_ff[7:4];
      q_rec.received_check = check_ff;
      q_rec.computed_check = crc_ff;
      q_rec.term_ok        = (req_data_byte == term_ff);
   end

endmodule

// ----- design/ccfr_queue.sv -----
// ----------------------------------------------------------------------------
// ccfr queue
// short frame record queue between front and back
// ----------------------------------------------------------------------------
module ccfr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  ccfr_pkg::frame_rec_type push_rec,
   output logic full,
   input  logic pop,
   output logic empty,
   output ccfr_pkg::frame_rec_type pop_rec
);
   import ccfr_pkg::*;

   frame_rec_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_rec = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/ccfr_back.sv -----
// ----------------------------------------------------------------------------
// ccfr back
// status decision and result output register
// ----------------------------------------------------------------------------
module ccfr_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  ccfr_pkg::frame_rec_type q_rec,
   output logic q_pop,
   ccfr_rsp_if.source rsp_chan
);
   import ccfr_pkg::*;

   logic valid_ff;
   frame_rec_type rec_ff;
   status_type status_ff, status_in;

   assign q_pop = !q_empty && (!valid_ff || rsp_chan.ready);

   always_comb begin
      if (!q_rec.term_ok) begin
         status_in = STATUS_NO_TERM;
      end else if (q_rec.computed_check != q_rec.received_check) begin
         status_in = STATUS_BAD_CRC;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_chan.ready) begin
         valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff    <= q_rec;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.first_value    = rec_ff.first_value;
   assign rsp_chan.second_value   = rec_ff.second_value;
   assign rsp_chan.low_nibble     = rec_ff.low_nibble;
   assign rsp_chan.high_nibble    = rec_ff.high_nibble;
   assign rsp_chan.received_check = rec_ff.received_check;
   assign rsp_chan.computed_check = rec_ff.computed_check;
   assign rsp_chan.status         = status_ff;

endmodule

// ----- design/crc_checked_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// crc checked frame receiver top
// six-byte serial frames checked with crc-16 (poly 8005, init ffff)
//
// channel   dir  transfer
// req_chan  in   one received byte
// rsp_chan  out  one frame result, at the terminator byte
// csr_*     in   terminator byte value
//
// one byte accepted per cycle unless a terminator byte stalls; the crc advances as each data byte is taken
// a frame result passes through the queue and the output register before it is valid on rsp_chan
// a two-entry queue sits between assembly and the output register
// only a terminator byte stalls, when that queue is full
// synchronous reset; terminator value resets to newline
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_top (
   input  logic clock,
   input  logic reset,
   ccfr_req_if.sink req_chan,
   ccfr_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import ccfr_pkg::*;

   logic q_push, q_full, q_pop, q_empty;
   frame_rec_type push_rec, pop_rec;

   ccfr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_data_byte(req_chan.data_byte),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_rec(push_rec)
   );

   ccfr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_rec(push_rec),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .pop_rec(pop_rec)
   );

   ccfr_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_rec(pop_rec),
      .q_pop(q_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

// ----- design/ccfr_checker.sv -----
// ----------------------------------------------------------------------------
// ccfr checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "crc_checked_frame_receiver_top_defines.svh"

module ccfr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [15:0] rsp_received_check,
   input logic [15:0] rsp_computed_check,
   input logic [1:0] rsp_status
);
   import ccfr_pkg::*;

   `CCFR_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_status) && $stable(rsp_computed_check)), "result changed while stalled")
   `CCFR_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_NO_TERM || rsp_status == STATUS_BAD_CRC, "undefined status code")
   `CCFR_ASSERT_IMPL(a_ok_match, clock, reset, rsp_valid && rsp_status == STATUS_OK, rsp_received_check == rsp_computed_check, "ok status with check mismatch")
   `CCFR_ASSERT_IMPL(a_bad_mismatch, clock, reset, rsp_valid && rsp_status == STATUS_BAD_CRC, rsp_received_check != rsp_computed_check, "crc error with matching check")

endmodule

bind crc_checked_frame_receiver_top ccfr_checker u_ccfr_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_received_check(rsp_chan.received_check),
   .rsp_computed_check(rsp_chan.computed_check),
   .rsp_status(rsp_chan.status)
);
